// File: design/qsc_pkg.sv
// Package for the quadrature step counter: widths, codes, register indexes,
// the seven-phase decode table and the value conversion helpers.
// No dependencies; every design file imports it.
`default_nettype none

package qsc_pkg;

  // Counter and elapsed-tick widths
  localparam int VALUE_WIDTH = 32;
  localparam int TICK_WIDTH  = 16;

  // Fixed field widths
  localparam int REG_W     = 32;
  localparam int BOOST_W   = 16;
  localparam int PHASE_W   = 3;
  localparam int DIR_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Working widths for the step arithmetic and the tick compare
  localparam int ARITH_W = ((VALUE_WIDTH > BOOST_W) ? VALUE_WIDTH : BOOST_W) + 2;
  localparam int TCMP_W  = (TICK_WIDTH > BOOST_W) ? TICK_WIDTH : BOOST_W;

  // Stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - REG_W - 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_STEP  = 3'd5;

  // Register reset values
  localparam logic [REG_W-1:0]   MIN_RESET        = 32'd0;
  localparam logic [REG_W-1:0]   MAX_RESET        = 32'd100;
  localparam logic [REG_W-1:0]   START_RESET      = 32'd0;
  localparam logic [BOOST_W-1:0] BOOST_STEP_RESET = 16'd1;

  // Item kinds
  localparam logic REQ_PIN  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result direction
  localparam logic OUT_DIR_UP   = 1'b0;
  localparam logic OUT_DIR_DOWN = 1'b1;

  // Direction of the last counted step
  localparam logic [DIR_W-1:0] LAST_NONE = 2'd0;
  localparam logic [DIR_W-1:0] LAST_UP   = 2'd1;
  localparam logic [DIR_W-1:0] LAST_DOWN = 2'd2;

  // Decoder phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CW1    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CW2    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CW3    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CCW1   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CCW2   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_CCW3   = 3'd6;
  localparam logic [PHASE_W-1:0] PH_UNUSED = 3'd7;

  // Pin pair codes, A in the high bit
  localparam logic [1:0] PINS_LL = 2'd0;
  localparam logic [1:0] PINS_LH = 2'd1;
  localparam logic [1:0] PINS_HL = 2'd2;
  localparam logic [1:0] PINS_HH = 2'd3;

  // Table entry flags
  localparam logic [7:0] FLAG_UP    = 8'h80;
  localparam logic [7:0] FLAG_DOWN  = 8'h40;
  localparam logic [7:0] PHASE_MASK = 8'h0f;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] min_value;
    logic [VALUE_WIDTH-1:0] max_value;
    logic                   wrap_mode;
    logic [BOOST_W-1:0]     boost_ticks;
    logic [BOOST_W-1:0]     boost_step;
  } qsc_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic [VALUE_WIDTH-1:0] count;
    logic [TICK_WIDTH-1:0]  ticks;
    logic [DIR_W-1:0]       last_dir;
  } qsc_state_t;

  typedef struct packed {
    qsc_state_t             st_nxt;
    logic                   counted;
    logic                   emit;
    logic                   dir;
    logic [VALUE_WIDTH-1:0] value;
    logic                   div_start;
    logic [BOOST_W-1:0]     div_dividend;
    logic [BOOST_W-1:0]     div_divisor;
    logic [VALUE_WIDTH-1:0] div_base;
  } qsc_step_t;

  // Seven-phase bounce-tolerant table; unused phase acts as idle
  function automatic logic [7:0] next_phase(input logic [PHASE_W-1:0] ph,
                                             input logic [1:0] pins);
    logic [7:0] e;
    e = 8'(PH_IDLE);
    unique case (ph)
      PH_CW1: begin
        case (pins)
          PINS_LL: e = 8'(PH_CW2);
          PINS_LH, PINS_HL: e = 8'(PH_CW1);
          default: e = 8'(PH_IDLE);
        endcase
      end
      PH_CW2: begin
        case (pins)
          PINS_LL: e = 8'(PH_CW2);
          PINS_LH: e = 8'(PH_CW1);
          PINS_HL: e = 8'(PH_CW3);
          default: e = 8'(PH_IDLE);
        endcase
      end
      PH_CW3: begin
        case (pins)
          PINS_LL: e = 8'(PH_CW2);
          PINS_LH, PINS_HL: e = 8'(PH_CW3);
          default: e = 8'(PH_IDLE) | FLAG_UP;
        endcase
      end
      PH_CCW1: begin
        case (pins)
          PINS_LL: e = 8'(PH_CCW2);
          PINS_LH, PINS_HL: e = 8'(PH_CCW1);
          default: e = 8'(PH_IDLE);
        endcase
      end
      PH_CCW2: begin
        case (pins)
          PINS_LL: e = 8'(PH_CCW2);
          PINS_LH: e = 8'(PH_CCW3);
          PINS_HL: e = 8'(PH_CCW1);
          default: e = 8'(PH_IDLE);
        endcase
      end
      PH_CCW3: begin
        case (pins)
          PINS_LL: e = 8'(PH_CCW2);
          PINS_LH, PINS_HL: e = 8'(PH_CCW3);
          default: e = 8'(PH_IDLE) | FLAG_DOWN;
        endcase
      end
      PH_IDLE, PH_UNUSED: begin
        case (pins)
          PINS_LH: e = 8'(PH_CW1);
          PINS_HL: e = 8'(PH_CCW1);
          default: e = 8'(PH_IDLE);
        endcase
      end
      default: e = 8'(PH_IDLE);
    endcase
    return e;
  endfunction

  // Register word to counter width, sign kept
  function automatic logic [VALUE_WIDTH-1:0] to_value(input logic [REG_W-1:0] d);
    logic signed [63:0] e;
    e = 64'(signed'(d));
    return e[VALUE_WIDTH-1:0];
  endfunction

  // Counter to result word, sign-extended then cut
  function automatic logic [REG_W-1:0] from_value(input logic [VALUE_WIDTH-1:0] v);
    logic signed [63:0] e;
    e = 64'(signed'(v));
    return e[REG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/quadrature_step_counter.sv
// Quadrature step counter: one item per cycle when the remainder unit is idle and
// the result slot is free; an item goes through the input register, then the result
// register. A wrapped step whose overshoot is at least the range size runs the
// bit-serial remainder unit, during which no item is processed. Reset
// (synchronous, rst_n low) puts the registers at their reset values, phase
// idle, counter 0, tick count all ones. Depends on qsc_pkg, qsc_step, qsc_remainder.
`default_nettype none

module quadrature_step_counter
  import qsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: pin_a [0], pin_b [1], zero pad [7:2]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type [0]
  input  wire logic                   in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // out_tdata: direction [0], new_value [32:1], zero pad [39:33]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [REG_W-1:0]       cfg_data
);

  qsc_cfg_t   cfg_r, cfg_nxt;
  qsc_state_t st_r, st_nxt;
  qsc_step_t  res;

  logic                   in_valid_r, in_valid_nxt;
  logic                   in_req_r, in_a_r, in_b_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_dir_r, out_dir_nxt;
  logic [REG_W-1:0]       out_value_r, out_value_nxt;
  logic [VALUE_WIDTH-1:0] pend_base_r;
  logic                   pend_down_r;
  logic [VALUE_WIDTH-1:0] wrap_value;

  logic               fire;
  logic               out_room;
  logic               cfg_wr;
  logic               div_busy;
  logic               div_done;
  logic               div_take;
  logic [BOOST_W-1:0] div_rem;

  qsc_step u_step (
    .req_type (in_req_r),
    .pin_a    (in_a_r),
    .pin_b    (in_b_r),
    .st       (st_r),
    .cfg      (cfg_r),
    .res      (res)
  );

  qsc_remainder u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (fire && res.div_start),
    .dividend (res.div_dividend),
    .divisor  (res.div_divisor),
    .take     (div_take),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Handshake: result slot free, item held until processed
  assign out_room  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && !div_busy && !div_done && (out_room || !res.emit);
  assign div_take  = div_done && out_room;
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Finish a wrapped step from the remainder
  assign wrap_value = pend_down_r ? (pend_base_r - VALUE_WIDTH'(div_rem))
                                  : (pend_base_r + VALUE_WIDTH'(div_rem));

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_MIN_VALUE:   cfg_nxt.min_value   = to_value(cfg_data);
        CFG_MAX_VALUE:   cfg_nxt.max_value   = to_value(cfg_data);
        CFG_WRAP_MODE:   cfg_nxt.wrap_mode   = cfg_data[0];
        CFG_BOOST_TICKS: cfg_nxt.boost_ticks = cfg_data[BOOST_W-1:0];
        CFG_BOOST_STEP:  cfg_nxt.boost_step  = cfg_data[BOOST_W-1:0];
        default: ;
      endcase
    end
  end

  // Decoder state: step result, remainder finish, counter load
  always_comb begin
    st_nxt = st_r;
    if (fire) begin
      st_nxt = res.st_nxt;
    end
    if (div_take) begin
      st_nxt.count = wrap_value;
    end
    if (cfg_wr && cfg_index == CFG_START_VALUE) begin
      st_nxt.count = to_value(cfg_data);
    end
  end

  // Input register and result register
  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    out_dir_nxt   = out_dir_r;
    out_value_nxt = out_value_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire && res.emit) begin
      out_valid_nxt = 1'b1;
      out_dir_nxt   = res.dir;
      out_value_nxt = from_value(res.value);
    end else if (div_take) begin
      out_valid_nxt = 1'b1;
      out_dir_nxt   = pend_down_r ? OUT_DIR_DOWN : OUT_DIR_UP;
      out_value_nxt = from_value(wrap_value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value   <= to_value(MIN_RESET);
      cfg_r.max_value   <= to_value(MAX_RESET);
      cfg_r.wrap_mode   <= 1'b0;
      cfg_r.boost_ticks <= '0;
      cfg_r.boost_step  <= BOOST_STEP_RESET;
      st_r.phase        <= PH_IDLE;
      st_r.count        <= to_value(START_RESET);
      st_r.ticks        <= '1;
      st_r.last_dir     <= LAST_NONE;
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_req_r <= in_tuser;
      in_a_r   <= in_tdata[0];
      in_b_r   <= in_tdata[1];
    end
    if (fire && res.div_start) begin
      pend_base_r <= res.div_base;
      pend_down_r <= (res.dir == OUT_DIR_DOWN);
    end
    out_dir_r   <= out_dir_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_value_r, out_dir_r};

`ifndef SYNTHESIS
  // No item is processed while the remainder unit owns the counter
  a_no_fire_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_busy || div_done) |-> !fire)
    else $error("item processed during remainder");

  // A waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !((fire && res.emit) || div_take))
    else $error("result register overwritten");

  // A counted step clears the elapsed tick count
  a_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.counted) |=> (st_r.ticks == '0))
    else $error("tick count not cleared after step");
`endif

endmodule

`default_nettype wire

// File: design/qsc_remainder.sv
// Bit-serial remainder unit for wrap overshoot: one dividend bit per cycle.
// Depends on qsc_pkg for BOOST_W.
`default_nettype none

module qsc_remainder
  import qsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [BOOST_W-1:0] dividend,
  input  wire logic [BOOST_W-1:0] divisor,
  input  wire logic               take,
  output logic                    busy,
  output logic                    done,
  output logic [BOOST_W-1:0]      rem
);

  localparam int CNT_W = $clog2(BOOST_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BOOST_W-1:0] dvd_r, dvd_nxt;
  logic [BOOST_W-1:0] dvs_r, dvs_nxt;
  logic [BOOST_W-1:0] rem_r, rem_nxt;
  logic [BOOST_W:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[BOOST_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = BOOST_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[BOOST_W-1:0];
      end
      dvd_nxt = {dvd_r[BOOST_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(BOOST_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (take) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: design/qsc_step.sv
// Step logic: phase table, boost check, clamp or wrap of the counter, and
// the tick counter update for one item. Depends on qsc_pkg.
`default_nettype none

module qsc_step
  import qsc_pkg::*;
(
  input  wire logic       req_type,
  input  wire logic       pin_a,
  input  wire logic       pin_b,
  input  wire qsc_state_t st,
  input  wire qsc_cfg_t   cfg,
  output qsc_step_t       res
);

  logic [7:0]                entry;
  logic                      up;
  logic                      down;
  logic                      boost;
  logic [BOOST_W-1:0]        incr;
  logic signed [ARITH_W-1:0] v, lo, mx, hi, inc_a, d_up, d_dn, rng, ovr, val;

  // Decode the pin pair and pick the step size
  always_comb begin
    entry = next_phase(st.phase, {pin_a, pin_b});
    up    = (entry & FLAG_UP) != '0;
    down  = (entry & FLAG_DOWN) != '0;
    boost = (TCMP_W'(st.ticks) < TCMP_W'(cfg.boost_ticks)) &&
            ((up && st.last_dir == LAST_UP) || (down && st.last_dir == LAST_DOWN));
    incr  = BOOST_W'(1);
    if (boost && cfg.boost_step != '0) begin
      incr = cfg.boost_step;
    end
  end

  // Distances to the limits, all in a width with headroom
  always_comb begin
    v     = ARITH_W'(signed'(st.count));
    lo    = ARITH_W'(signed'(cfg.min_value));
    mx    = ARITH_W'(signed'(cfg.max_value));
    hi    = (mx >= lo) ? mx : lo;
    inc_a = signed'(ARITH_W'(incr));
    d_up  = hi - v;
    d_dn  = v - lo;
    rng   = hi - lo + ARITH_W'(1);
  end

  // Move the counter and drive the next state
  always_comb begin
    res        = '0;
    res.st_nxt = st;
    val        = v;
    ovr        = '0;
    res.dir    = up ? OUT_DIR_UP : OUT_DIR_DOWN;
    if (req_type == REQ_TICK) begin
      if (st.ticks != '1) begin
        res.st_nxt.ticks = st.ticks + 1'b1;
      end
    end else begin
      res.st_nxt.phase = PHASE_W'(entry & PHASE_MASK);
      if (up || down) begin
        res.counted           = 1'b1;
        res.emit              = 1'b1;
        res.st_nxt.ticks      = '0;
        res.st_nxt.last_dir   = up ? LAST_UP : LAST_DOWN;
        if (up) begin
          ovr = inc_a - d_up - ARITH_W'(1);
          if (v <= hi && d_up >= inc_a) begin
            val = v + inc_a;
          end else if (!cfg.wrap_mode) begin
            res.emit = (v != hi);
            val      = hi;
          end else if (v > hi) begin
            val = lo;
          end else if (ovr < rng) begin
            val = lo + ovr;
          end else begin
            res.div_start = 1'b1;
            res.div_base  = VALUE_WIDTH'(lo);
          end
        end else begin
          ovr = inc_a - d_dn - ARITH_W'(1);
          if (v >= lo && d_dn >= inc_a) begin
            val = v - inc_a;
          end else if (!cfg.wrap_mode) begin
            res.emit = (v != lo);
            val      = lo;
          end else if (v < lo) begin
            val = hi;
          end else if (ovr < rng) begin
            val = hi - ovr;
          end else begin
            res.div_start = 1'b1;
            res.div_base  = VALUE_WIDTH'(hi);
          end
        end
        // Remainder path finishes the result later
        if (res.div_start) begin
          res.emit = 1'b0;
        end else begin
          res.st_nxt.count = VALUE_WIDTH'(val);
        end
      end
    end
    res.value        = VALUE_WIDTH'(val);
    res.div_dividend = BOOST_W'(ovr);
    res.div_divisor  = BOOST_W'(rng);
  end

endmodule

`default_nettype wire
